### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL files; the top level uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked property, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Types, codes and constants of the pitch step accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

    localparam int OP_W      = 3;
    localparam int IDX_W     = 7;
    localparam int RAT_W     = 4;
    localparam int INC_W     = 7;
    localparam int VAL_W     = 8;
    localparam int CNT_W     = 16;
    localparam int SS_W      = 5;
    localparam int MODE_W    = 3;
    localparam int THR_W     = 8;
    localparam int DELTA_W   = INC_W + SS_W;
    localparam int SUM_W     = DELTA_W + 2;
    localparam int RANGE_W   = VAL_W + 1;
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int APB_W     = 32;

    localparam int INITIAL_VALUE_DEF = 0;
    localparam bit WRAP_ENABLE_DEF   = 1'b0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_STEP     = 3'd0;
    localparam logic [OP_W-1:0] OP_MANUAL   = 3'd1;
    localparam logic [OP_W-1:0] OP_RST_NOW  = 3'd2;
    localparam logic [OP_W-1:0] OP_RST_DEF  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOP_END = 3'd4;

    // Accumulate modes
    localparam logic [MODE_W-1:0] MODE_STAGE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RATCHET = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEND    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MANUAL  = 3'd4;

    // Reset strategies
    localparam logic [MODE_W-1:0] STRAT_NEVER    = 3'd0;
    localparam logic [MODE_W-1:0] STRAT_LOOP_END = 3'd1;
    localparam logic [MODE_W-1:0] STRAT_COUNT    = 3'd2;
    localparam logic [MODE_W-1:0] STRAT_LIMIT    = 3'd3;
    localparam logic [MODE_W-1:0] STRAT_MANUAL   = 3'd4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STRATEGY   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOWER      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_UPPER      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SWING_LOW  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SWING_HIGH = 3'd7;

    // Register reset values
    localparam logic signed [SS_W-1:0]  STEP_SIZE_RST  = 5'sd1;
    localparam logic [MODE_W-1:0]       MODE_RST       = MODE_STAGE;
    localparam logic [MODE_W-1:0]       STRATEGY_RST   = STRAT_LOOP_END;
    localparam logic [THR_W-1:0]        THRESHOLD_RST  = 8'd8;
    localparam logic signed [VAL_W-1:0] LOWER_RST      = -8'sd24;
    localparam logic signed [VAL_W-1:0] UPPER_RST      = 8'sd24;
    localparam logic signed [VAL_W-1:0] SWING_LOW_RST  = -8'sd12;
    localparam logic signed [VAL_W-1:0] SWING_HIGH_RST = 8'sd12;

    typedef struct packed {
        logic signed [SS_W-1:0]  step_size;
        logic [MODE_W-1:0]       accumulate_mode;
        logic [MODE_W-1:0]       reset_strategy;
        logic [THR_W-1:0]        reset_threshold;
        logic signed [VAL_W-1:0] lower_limit;
        logic signed [VAL_W-1:0] upper_limit;
        logic signed [VAL_W-1:0] swing_low;
        logic signed [VAL_W-1:0] swing_high;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_status;

endpackage

`default_nettype wire

### design/pitch_step_accumulator_top.sv
// ----------------------------------------------------------------------------
// pitch_step_accumulator_top: transposition accumulator for a step sequencer.
// An accepted item passes the execute state, with wrap enabled the iterations of
// the one-bit-per-cycle modulo unit, then commit and the output register.
// One item is in flight: the next input is taken once the result is committed,
// and an untaken result holds the next input back.
// Synchronous active-low reset restores configuration, control and accumulator state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pitch_step_accumulator_top
    import psa_pkg::*;
#(
    parameter int INITIAL_VALUE = INITIAL_VALUE_DEF,
    parameter bit WRAP_ENABLE   = WRAP_ENABLE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // [6:0] stage_index, [13:7] pulse_index, [17:14] ratchet_index,
    // [24:18] increment_value, [31:25] zero
    input  wire logic [31:0]       i_s_tdata,
    // [2:0] operation
    input  wire logic [OP_W-1:0]   i_s_tuser,
    // Result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // [7:0] current_value, [23:8] steps_since_reset, [24] reset_pending,
    // [25] did_accumulate, [31:26] zero
    output logic [31:0]            o_m_tdata,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]       prdata,
    output logic                   pready
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;

    logic signed [VAL_W-1:0] w_current_value;
    logic [CNT_W-1:0]        w_steps_since_reset;
    logic                    w_reset_pending, w_did_accumulate;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size       <= STEP_SIZE_RST;
            r_cfg.accumulate_mode <= MODE_RST;
            r_cfg.reset_strategy  <= STRATEGY_RST;
            r_cfg.reset_threshold <= THRESHOLD_RST;
            r_cfg.lower_limit     <= LOWER_RST;
            r_cfg.upper_limit     <= UPPER_RST;
            r_cfg.swing_low       <= SWING_LOW_RST;
            r_cfg.swing_high      <= SWING_HIGH_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_STEP_SIZE:  r_cfg.step_size       <= pwdata[SS_W-1:0];
                REG_MODE:       r_cfg.accumulate_mode <= pwdata[MODE_W-1:0];
                REG_STRATEGY:   r_cfg.reset_strategy  <= pwdata[MODE_W-1:0];
                REG_THRESHOLD:  r_cfg.reset_threshold <= pwdata[THR_W-1:0];
                REG_LOWER:      r_cfg.lower_limit     <= pwdata[VAL_W-1:0];
                REG_UPPER:      r_cfg.upper_limit     <= pwdata[VAL_W-1:0];
                REG_SWING_LOW:  r_cfg.swing_low       <= pwdata[VAL_W-1:0];
                REG_SWING_HIGH: r_cfg.swing_high      <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_STEP_SIZE:  prdata = APB_W'(r_cfg.step_size);
            REG_MODE:       prdata = APB_W'(r_cfg.accumulate_mode);
            REG_STRATEGY:   prdata = APB_W'(r_cfg.reset_strategy);
            REG_THRESHOLD:  prdata = APB_W'(r_cfg.reset_threshold);
            REG_LOWER:      prdata = APB_W'(r_cfg.lower_limit);
            REG_UPPER:      prdata = APB_W'(r_cfg.upper_limit);
            REG_SWING_LOW:  prdata = APB_W'(r_cfg.swing_low);
            REG_SWING_HIGH: prdata = APB_W'(r_cfg.swing_high);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller and datapath
    // ------------------------------------------------------------------
    psa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    psa_datapath #(
        .INITIAL_VALUE (INITIAL_VALUE),
        .WRAP_ENABLE   (WRAP_ENABLE)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_cfg               (r_cfg),
        .i_operation         (i_s_tuser),
        .i_stage_index       (i_s_tdata[6:0]),
        .i_pulse_index       (i_s_tdata[13:7]),
        .i_ratchet_index     (i_s_tdata[17:14]),
        .i_increment_value   (i_s_tdata[24:18]),
        .o_status            (w_status),
        .o_current_value     (w_current_value),
        .o_steps_since_reset (w_steps_since_reset),
        .o_reset_pending     (w_reset_pending),
        .o_did_accumulate    (w_did_accumulate)
    );

    assign o_m_tdata = {6'b0, w_did_accumulate, w_reset_pending,
                        w_steps_since_reset, w_current_value};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_commit_free, i_clk, i_rst_n, w_cmd.commit |-> (!o_m_tvalid || i_m_tready), "result written over an untaken transaction")
    `ASSERT_CLK(a_accept_exec, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> w_cmd.exec, "accepted transaction not executed next cycle")
    `ASSERT_CLK_ALWAYS(a_cmd_onehot, i_clk, $onehot0({w_cmd.load, w_cmd.exec, w_cmd.div_step, w_cmd.commit}), "more than one command active")
    `ASSERT_CLK(a_commit_valid, i_clk, i_rst_n, w_cmd.commit |=> o_m_tvalid, "committed result not presented")

endmodule

`default_nettype wire

### design/psa_ctrl.sv
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer of the accumulator: input acceptance, execution, the modulo
// iterations and the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_ctrl
    import psa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_status.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_status.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_DONE: o_cmd.commit = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    // A committed result refills the output register in the same cycle that
    // the previous one is taken.
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

### design/psa_datapath.sv
// ----------------------------------------------------------------------------
// psa_datapath
// Accumulator state, step arithmetic, limiting, bit-serial modulo for the
// wrap range and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_datapath
    import psa_pkg::*;
#(
    parameter int INITIAL_VALUE = INITIAL_VALUE_DEF,
    parameter bit WRAP_ENABLE   = WRAP_ENABLE_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    input  wire t_cfg                    i_cfg,
    input  wire logic [OP_W-1:0]         i_operation,
    input  wire logic [IDX_W-1:0]        i_stage_index,
    input  wire logic [IDX_W-1:0]        i_pulse_index,
    input  wire logic [RAT_W-1:0]        i_ratchet_index,
    input  wire logic signed [INC_W-1:0] i_increment_value,
    output t_status                      o_status,
    output logic signed [VAL_W-1:0]      o_current_value,
    output logic [CNT_W-1:0]             o_steps_since_reset,
    output logic                         o_reset_pending,
    output logic                         o_did_accumulate
);

    localparam logic signed [VAL_W-1:0] INIT_V  = VAL_W'(INITIAL_VALUE);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2**(VAL_W-1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(2**(VAL_W-1));

    // Latched item
    logic [OP_W-1:0]         r_op;
    logic [IDX_W-1:0]        r_stage, r_pulse;
    logic [RAT_W-1:0]        r_ratchet;
    logic signed [INC_W-1:0] r_inc;

    // Architectural state
    logic signed [VAL_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_pend, n_pend;
    logic                    r_swing_up, n_swing_up;
    logic [IDX_W:0]          r_prev_stage, n_prev_stage;
    logic [IDX_W:0]          r_prev_pulse, n_prev_pulse;
    logic [RAT_W:0]          r_prev_ratchet, n_prev_ratchet;

    // Execution results
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_did, r_clear, r_limit;

    // Modulo unit
    logic [SUM_W-1:0]   r_mag;
    logic               r_neg;
    logic [RANGE_W-1:0] r_rem;
    logic [DCNT_W-1:0]  r_div_cnt;

    // Output register
    logic signed [VAL_W-1:0] r_out_value;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_out_pend, r_out_did;

    logic                    w_is_step, w_is_man, w_sc, w_pc, w_rc, w_mode_go;
    logic                    w_go, w_clear, w_accum, w_pend_mode, w_down, w_use_limit;
    logic                    w_ordered;
    logic signed [VAL_W-1:0] w_base;
    logic signed [DELTA_W-1:0] w_delta;
    logic signed [SUM_W-1:0] w_operand, w_sum, w_dist;
    logic [RANGE_W-1:0]      w_range, w_wrap_r;
    logic [RANGE_W:0]        w_trial;
    logic signed [RANGE_W:0] w_wrap_sum;
    logic signed [VAL_W-1:0] w_wrapped, w_clamped, w_limited, w_swing_val, w_new_acc;
    logic                    w_flip;
    logic [CNT_W-1:0]        w_base_cnt, w_new_cnt;
    logic                    w_check;

    // ------------------------------------------------------------------
    // Execution: decide whether the item accumulates and form the sum.
    // ------------------------------------------------------------------
    assign w_is_step = (r_op == OP_STEP);
    assign w_is_man  = (r_op == OP_MANUAL);
    assign w_sc = ({1'b0, r_stage} != r_prev_stage);
    assign w_pc = ({1'b0, r_pulse} != r_prev_pulse);
    assign w_rc = ({1'b0, r_ratchet} != r_prev_ratchet);

    always_comb begin
        unique case (i_cfg.accumulate_mode)
            MODE_STAGE, MODE_PEND: w_mode_go = w_sc;
            MODE_PULSE:            w_mode_go = w_sc || w_pc;
            MODE_RATCHET:          w_mode_go = w_sc || w_pc || w_rc;
            default:               w_mode_go = 1'b0;
        endcase
    end

    assign w_go        = w_is_step && w_mode_go;
    assign w_clear     = w_is_step && r_pend;
    assign w_accum     = w_go || w_is_man;
    assign w_pend_mode = (i_cfg.accumulate_mode == MODE_PEND);
    assign w_use_limit = w_is_man || !w_pend_mode;
    assign w_down      = w_is_step && w_pend_mode && !r_swing_up;
    assign w_base      = w_clear ? INIT_V : r_acc;
    assign w_delta     = DELTA_W'(r_inc) * DELTA_W'(i_cfg.step_size);
    assign w_operand   = w_is_man ? SUM_W'(r_inc) : SUM_W'(w_delta);
    assign w_sum       = w_down ? (SUM_W'(w_base) - w_operand)
                                : (SUM_W'(w_base) + w_operand);
    assign w_dist      = w_sum - SUM_W'(i_cfg.lower_limit);
    assign w_ordered   = (i_cfg.lower_limit < i_cfg.upper_limit);
    assign w_range     = RANGE_W'(RANGE_W'(i_cfg.upper_limit) - RANGE_W'(i_cfg.lower_limit)
                                  + RANGE_W'(1));

    assign o_status.need_div = WRAP_ENABLE && w_accum && w_use_limit && w_ordered;
    assign o_status.div_last = (r_div_cnt == DCNT_W'(DIV_STEPS - 1));

    // One remainder bit per cycle over the magnitude of the distance.
    assign w_trial = {r_rem, r_mag[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_stage   <= i_stage_index;
            r_pulse   <= i_pulse_index;
            r_ratchet <= i_ratchet_index;
            r_inc     <= i_increment_value;
        end
        if (i_cmd.exec) begin
            r_sum     <= w_sum;
            r_did     <= w_accum;
            r_clear   <= w_clear;
            r_limit   <= w_use_limit;
            r_neg     <= w_dist[SUM_W-1];
            r_mag     <= w_dist[SUM_W-1] ? SUM_W'(-w_dist) : SUM_W'(w_dist);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_mag     <= {r_mag[SUM_W-2:0], 1'b0};
            r_rem     <= (w_trial >= {1'b0, w_range}) ? RANGE_W'(w_trial - {1'b0, w_range})
                                                      : RANGE_W'(w_trial);
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
        if (i_cmd.commit) begin
            r_out_value <= w_new_acc;
            r_out_count <= w_new_cnt;
            r_out_pend  <= n_pend;
            r_out_did   <= r_did;
        end
    end

    // ------------------------------------------------------------------
    // Commit: limit the sum and update the state.
    // ------------------------------------------------------------------
    assign w_wrap_r   = (r_neg && (r_rem != '0)) ? (w_range - r_rem) : r_rem;
    assign w_wrap_sum = (RANGE_W+1)'(i_cfg.lower_limit) + $signed({1'b0, w_wrap_r});
    assign w_wrapped  = VAL_W'(w_wrap_sum);

    always_comb begin
        if (r_sum < SUM_W'(i_cfg.lower_limit)) begin
            w_clamped = i_cfg.lower_limit;
        end else if (r_sum > SUM_W'(i_cfg.upper_limit)) begin
            w_clamped = i_cfg.upper_limit;
        end else begin
            w_clamped = VAL_W'(r_sum);
        end
    end

    always_comb begin
        if (!w_ordered) begin
            w_limited = i_cfg.lower_limit;
        end else if (WRAP_ENABLE) begin
            w_limited = w_wrapped;
        end else begin
            w_limited = w_clamped;
        end
    end

    // Pendulum: reaching or overshooting a turning point lands on it and turns around.
    always_comb begin
        w_flip = 1'b0;
        if (r_swing_up && (r_sum >= SUM_W'(i_cfg.swing_high))) begin
            w_swing_val = i_cfg.swing_high;
            w_flip      = 1'b1;
        end else if (!r_swing_up && (r_sum <= SUM_W'(i_cfg.swing_low))) begin
            w_swing_val = i_cfg.swing_low;
            w_flip      = 1'b1;
        end else if (r_sum > SAT_MAX) begin
            w_swing_val = VAL_W'(SAT_MAX);
        end else if (r_sum < SAT_MIN) begin
            w_swing_val = VAL_W'(SAT_MIN);
        end else begin
            w_swing_val = VAL_W'(r_sum);
        end
    end

    always_comb begin
        if (r_op == OP_RST_NOW) begin
            w_new_acc  = INIT_V;
            w_base_cnt = '0;
        end else begin
            w_new_acc  = r_clear ? INIT_V : r_acc;
            w_base_cnt = r_clear ? '0 : r_count;
            if (r_did) w_new_acc = r_limit ? w_limited : w_swing_val;
        end
        w_new_cnt = w_base_cnt;
        if (r_did && (w_base_cnt != '1)) w_new_cnt = w_base_cnt + CNT_W'(1);
    end

    always_comb begin
        unique case (i_cfg.reset_strategy)
            STRAT_COUNT: w_check = (w_new_cnt >= CNT_W'(i_cfg.reset_threshold));
            STRAT_LIMIT: w_check = (w_new_acc <= i_cfg.lower_limit)
                                || (w_new_acc >= i_cfg.upper_limit);
            default:     w_check = 1'b0;
        endcase
    end

    always_comb begin
        n_acc          = w_new_acc;
        n_count        = w_new_cnt;
        n_pend         = r_pend;
        n_swing_up     = r_swing_up;
        n_prev_stage   = r_prev_stage;
        n_prev_pulse   = r_prev_pulse;
        n_prev_ratchet = r_prev_ratchet;
        unique case (r_op)
            OP_STEP: begin
                // A waiting reset was applied before the step, so only the
                // new check can arm another one.
                n_pend         = r_did && w_check;
                n_prev_stage   = {1'b0, r_stage};
                n_prev_pulse   = {1'b0, r_pulse};
                n_prev_ratchet = {1'b0, r_ratchet};
                if (r_did && !r_limit && w_flip) n_swing_up = !r_swing_up;
            end
            OP_MANUAL:   n_pend = r_pend || w_check;
            OP_RST_NOW: begin
                n_pend         = 1'b0;
                n_swing_up     = 1'b1;
                n_prev_stage   = '1;
                n_prev_pulse   = '1;
                n_prev_ratchet = '1;
            end
            OP_RST_DEF:  n_pend = 1'b1;
            OP_LOOP_END: n_pend = r_pend || (i_cfg.reset_strategy == STRAT_LOOP_END);
            default:     n_pend = r_pend;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc          <= INIT_V;
            r_count        <= '0;
            r_pend         <= 1'b0;
            r_swing_up     <= 1'b1;
            r_prev_stage   <= '1;
            r_prev_pulse   <= '1;
            r_prev_ratchet <= '1;
        end else if (i_cmd.commit) begin
            r_acc          <= n_acc;
            r_count        <= n_count;
            r_pend         <= n_pend;
            r_swing_up     <= n_swing_up;
            r_prev_stage   <= n_prev_stage;
            r_prev_pulse   <= n_prev_pulse;
            r_prev_ratchet <= n_prev_ratchet;
        end
    end

    assign o_current_value     = r_out_value;
    assign o_steps_since_reset = r_out_count;
    assign o_reset_pending     = r_out_pend;
    assign o_did_accumulate    = r_out_did;

endmodule

`default_nettype wire
